// ----- hdl/hlw_pkg.sv -----
// Shared types, sizes and the lifting step for the 2D Haar lifting transform unit.
// Used by hlw_pass and haar_lifting_dwt_2d_unit; no other dependencies.
package hlw_pkg;

  localparam int MAX_DIM   = 512;
  localparam int DIM_W     = 10;
  localparam int LINE_W    = $clog2(MAX_DIM);
  localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int TOT_W     = ADDR_W + 1;
  localparam int COEF_W    = 10;

  // Configuration register indexes
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  // Input command carried on the slave-side tuser
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  // Result status carried on the master-side tuser
  typedef enum logic {
    ST_OK        = 1'b0,
    ST_NOT_READY = 1'b1
  } status_e;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Frame geometry handed to the pass sequencer
  typedef struct packed {
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [ADDR_W-1:0] half_total;
  } dims_t;

  // Memory read and write request from the pass sequencer
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    coef_t             wr_data;
  } mem_req_t;

  typedef struct packed {
    coef_t s;
    coef_t d;
  } lift_t;

  // Detail d = odd - even, approximation s = even + floor(d / 2)
  function automatic lift_t hlw_lift(coef_t e, coef_t o);
    logic signed [COEF_W:0] d;
    logic signed [COEF_W:0] s;
    lift_t r;
    d = $signed({o[COEF_W-1], o}) - $signed({e[COEF_W-1], e});
    s = $signed({e[COEF_W-1], e}) + (d >>> 1);
    r.d = d[COEF_W-1:0];
    r.s = s[COEF_W-1:0];
    return r;
  endfunction

endpackage

// ----- hdl/hlw_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; contents are undefined until written.
module hlw_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hdl/hlw_pass.sv -----
// Lifting pass sequencer: streams one store through the lifting step into the other.
// Row mode walks rows left to right, column mode walks columns top to bottom.
// Depends on hlw_pkg.
module hlw_pass (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             col_mode_i,
  input  hlw_pkg::dims_t   dims_i,
  input  hlw_pkg::coef_t   rd_data_i,
  output hlw_pkg::mem_req_t req_o,
  output logic             busy_o,
  output logic             done_o
);
  import hlw_pkg::*;

  logic              busy_q, col_q, reading_q, rvalid_q, odd_q, pend_q;
  logic [LINE_W-1:0] n_q, line_q;
  logic [LINE_W-2:0] m_q;
  logic [ADDR_W-1:0] rd_addr_q, rline_q, ws_q, wline_q;
  coef_t             even_q;
  logic [ADDR_W-1:0] pend_addr_q;
  coef_t             pend_data_q;

  logic [DIM_W-1:0]  len, lines;
  logic [ADDR_W-1:0] step_in, step_line, d_off;
  logic              n_last, line_last, m_last, quiet, wr_s;
  lift_t             lf;

  // Geometry of the current pass
  assign len       = col_q ? dims_i.h : dims_i.w;
  assign lines     = col_q ? dims_i.w : dims_i.h;
  assign step_in   = col_q ? ADDR_W'(dims_i.w) : ADDR_W'(1);
  assign step_line = col_q ? ADDR_W'(1) : ADDR_W'(dims_i.w);
  assign d_off     = col_q ? dims_i.half_total : ADDR_W'(dims_i.w[DIM_W-1:1]);

  assign n_last    = ({1'b0, n_q} == (len - DIM_W'(1)));
  assign line_last = ({1'b0, line_q} == (lines - DIM_W'(1)));
  assign m_last    = ({1'b0, m_q} == (len[DIM_W-1:1] - (DIM_W-1)'(1)));

  assign lf    = hlw_lift(even_q, rd_data_i);
  assign wr_s  = rvalid_q && odd_q;
  assign quiet = !reading_q && !rvalid_q && !pend_q;

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      col_q     <= 1'b0;
      reading_q <= 1'b0;
      rvalid_q  <= 1'b0;
      odd_q     <= 1'b0;
      pend_q    <= 1'b0;
      n_q       <= '0;
      line_q    <= '0;
      m_q       <= '0;
      rd_addr_q <= '0;
      rline_q   <= '0;
      ws_q      <= '0;
      wline_q   <= '0;
    end else if (start_i) begin
      busy_q    <= 1'b1;
      col_q     <= col_mode_i;
      reading_q <= 1'b1;
      rvalid_q  <= 1'b0;
      odd_q     <= 1'b0;
      pend_q    <= 1'b0;
      n_q       <= '0;
      line_q    <= '0;
      m_q       <= '0;
      rd_addr_q <= '0;
      rline_q   <= '0;
      ws_q      <= '0;
      wline_q   <= '0;
    end else begin
      if (busy_q && quiet) begin
        busy_q <= 1'b0;
      end
      rvalid_q <= reading_q;
      pend_q   <= wr_s;
      // Advance the read address, one entry a cycle
      if (reading_q) begin
        if (n_last) begin
          n_q       <= '0;
          rline_q   <= rline_q + step_line;
          rd_addr_q <= rline_q + step_line;
          line_q    <= line_q + LINE_W'(1);
          if (line_last) begin
            reading_q <= 1'b0;
          end
        end else begin
          n_q       <= n_q + LINE_W'(1);
          rd_addr_q <= rd_addr_q + step_in;
        end
      end
      // Advance the write address once per completed pair
      if (rvalid_q) begin
        odd_q <= !odd_q;
        if (odd_q) begin
          if (m_last) begin
            m_q     <= '0;
            wline_q <= wline_q + step_line;
            ws_q    <= wline_q + step_line;
          end else begin
            m_q  <= m_q + (LINE_W-1)'(1);
            ws_q <= ws_q + step_in;
          end
        end
      end
    end
  end

  // Hold the even sample and the pending detail write
  always_ff @(posedge clk_i) begin
    if (rvalid_q && !odd_q) begin
      even_q <= rd_data_i;
    end
    if (wr_s) begin
      pend_addr_q <= ws_q + d_off;
      pend_data_q <= lf.d;
    end
  end

  // Approximation goes out on the odd sample, detail in the cycle after
  always_comb begin
    req_o.rd_en   = reading_q;
    req_o.rd_addr = rd_addr_q;
    req_o.wr_en   = wr_s || pend_q;
    req_o.wr_addr = wr_s ? ws_q : pend_addr_q;
    req_o.wr_data = wr_s ? lf.s : pend_data_q;
  end

  assign busy_o = busy_q;
  assign done_o = busy_q && quiet;

  // The two writes of a pair never share a cycle
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni) !(wr_s && pend_q))
    else $error("approximation and detail writes collide");

  // A pending detail only follows an approximation write
  a_pend_after_s: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(wr_s))
    else $error("detail write without its pair");

endmodule

// ----- hdl/haar_lifting_dwt_2d_unit.sv -----
// One-level 2D integer Haar lifting transform over a frame of up to 512 x 512 pixels.
// A load is written to the frame store as it is taken. A read goes through the registered store
// read into the output register, or loads it at once if the frame is not ready. One load per
// cycle unless the output stalls; after a read no item is taken until its result is registered.
// The last load starts a row and a column pass, one store entry per cycle; no item is taken then.
// Reset: counts and ready flag clear, size 512 x 512; the stores are not cleared.
module haar_lifting_dwt_2d_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  logic        s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [9:0] coefficient, [15:10] zero
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // [0] status
);
  import hlw_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RDWAIT = 2'd1;
  localparam logic [1:0] ST_ROW    = 2'd2;
  localparam logic [1:0] ST_COL    = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [DIM_W-1:0] width_q, height_q, w_eff, h_eff;
  logic [TOT_W-1:0] total_q, load_count_q, read_count_q;
  logic             frame_ready_q, cfg_blk_q, rd_last_q;
  logic             out_valid_q, out_last_q, out_status_q;
  coef_t            out_coef_q;

  logic             in_acc, is_read, load_ok, load_we, load_fin, read_ok, rd_go, rd_err;
  logic             rd_last;
  logic             pass_start, pass_busy, pass_done;
  dims_t            dims;
  mem_req_t         preq;
  coef_t            frame_rdata, row_rdata, pass_rdata;
  logic             frame_we, frame_re, row_we, row_re;
  logic [ADDR_W-1:0] frame_waddr, frame_raddr;
  coef_t            frame_wdata;

  // Effective size: round down to even, clamp to 2..MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] e;
    e = {v[DIM_W-1:1], 1'b0};
    if (e < DIM_W'(2)) e = DIM_W'(2);
    if (e > DIM_W'(MAX_DIM)) e = DIM_W'(MAX_DIM);
    return e;
  endfunction

  assign w_eff = eff_dim(width_q);
  assign h_eff = eff_dim(height_q);

  assign dims.w          = w_eff;
  assign dims.h          = h_eff;
  assign dims.half_total = total_q[TOT_W-1:1];

  // Input decode
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_blk_q && (!out_valid_q || m_axis_tready);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign is_read  = (s_axis_tuser == CMD_READ);
  assign load_ok  = !frame_ready_q && (load_count_q < total_q);
  assign load_we  = in_acc && !is_read && load_ok;
  assign load_fin = load_we && ((load_count_q + TOT_W'(1)) == total_q);
  assign read_ok  = frame_ready_q && (read_count_q < total_q);
  assign rd_go    = in_acc && is_read && read_ok;
  assign rd_err   = in_acc && is_read && !read_ok;
  assign rd_last  = (read_count_q + TOT_W'(1)) == total_q;

  assign pass_start = load_fin || ((state_q == ST_ROW) && pass_done);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (load_fin) state_d = ST_ROW;
        else if (rd_go) state_d = ST_RDWAIT;
      end
      ST_RDWAIT: state_d = ST_IDLE;
      ST_ROW: begin
        if (pass_done) state_d = ST_COL;
      end
      ST_COL: begin
        if (pass_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, size registers and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      width_q       <= DIM_W'(MAX_DIM);
      height_q      <= DIM_W'(MAX_DIM);
      total_q       <= TOT_W'(MEM_DEPTH);
      cfg_blk_q     <= 1'b0;
      load_count_q  <= '0;
      read_count_q  <= '0;
      frame_ready_q <= 1'b0;
      rd_last_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      total_q   <= TOT_W'({{DIM_W{1'b0}}, w_eff} * {{DIM_W{1'b0}}, h_eff});
      cfg_blk_q <= cfg_we_i;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WIDTH:  width_q  <= cfg_data_i;
          REG_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
        load_count_q  <= '0;
        read_count_q  <= '0;
        frame_ready_q <= 1'b0;
      end else begin
        if (load_we) begin
          load_count_q <= load_count_q + TOT_W'(1);
        end
        if (rd_go) begin
          rd_last_q <= rd_last;
          if (rd_last) begin
            load_count_q  <= '0;
            read_count_q  <= '0;
            frame_ready_q <= 1'b0;
          end else begin
            read_count_q <= read_count_q + TOT_W'(1);
          end
        end
        if ((state_q == ST_COL) && pass_done) begin
          frame_ready_q <= 1'b1;
        end
      end
    end
  end

  // Output register: error results load at once, stored coefficients after the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rd_err || (state_q == ST_RDWAIT)) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_err) begin
      out_coef_q   <= '0;
      out_last_q   <= 1'b0;
      out_status_q <= ST_NOT_READY;
    end else if (state_q == ST_RDWAIT) begin
      out_coef_q   <= frame_rdata;
      out_last_q   <= rd_last_q;
      out_status_q <= ST_OK;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(16 - COEF_W){1'b0}}, out_coef_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_status_q;

  // Frame store: pixels and column pass results in, row pass reads and coefficient reads out
  assign frame_we    = load_we || ((state_q == ST_COL) && preq.wr_en);
  assign frame_waddr = load_we ? load_count_q[ADDR_W-1:0] : preq.wr_addr;
  assign frame_wdata = load_we ? coef_t'({2'b00, s_axis_tdata}) : preq.wr_data;
  assign frame_re    = rd_go || ((state_q == ST_ROW) && preq.rd_en);
  assign frame_raddr = (state_q == ST_ROW) ? preq.rd_addr : read_count_q[ADDR_W-1:0];

  // Row pass store: written by the row pass, read by the column pass
  assign row_we = (state_q == ST_ROW) && preq.wr_en;
  assign row_re = (state_q == ST_COL) && preq.rd_en;

  assign pass_rdata = (state_q == ST_COL) ? row_rdata : frame_rdata;

  hlw_ram #(
    .WIDTH(COEF_W),
    .DEPTH(MEM_DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (frame_we),
    .waddr_i (frame_waddr),
    .wdata_i (frame_wdata),
    .re_i    (frame_re),
    .raddr_i (frame_raddr),
    .rdata_o (frame_rdata)
  );

  hlw_ram #(
    .WIDTH(COEF_W),
    .DEPTH(MEM_DEPTH)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (preq.wr_addr),
    .wdata_i (preq.wr_data),
    .re_i    (row_re),
    .raddr_i (preq.rd_addr),
    .rdata_o (row_rdata)
  );

  hlw_pass u_pass (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (pass_start),
    .col_mode_i (state_q == ST_ROW),
    .dims_i     (dims),
    .rd_data_i  (pass_rdata),
    .req_o      (preq),
    .busy_o     (pass_busy),
    .done_o     (pass_done)
  );

  // A ready frame is a fully loaded frame
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_ready_q |-> (load_count_q == total_q))
    else $error("frame ready without a full load");

  // Coefficients are only read out of a ready frame
  a_read_needs_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !frame_ready_q |-> (read_count_q == '0))
    else $error("read count advanced before frame ready");

  // The sequencer runs only during the two passes
  a_pass_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pass_busy |-> ((state_q == ST_ROW) || (state_q == ST_COL)))
    else $error("pass sequencer busy outside a pass");

  // A stored read always lands in the output register
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RDWAIT) |=> m_axis_tvalid)
    else $error("read result lost");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for haar_lifting_dwt_2d_unit: drives pixel loads and coefficient reads
// over the stream ports and checks every coefficient against an in-bench transform.
// Depends on hlw_pkg for sizes, codes and the coefficient type.
module tb_top;
  import hlw_pkg::*;

  localparam int RANDOM_ITEMS = 350;

  typedef struct packed {
    coef_t coefficient;
    logic  last;
    logic  status;
  } coef_result_t;

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic        cfg_idx_i      = REG_WIDTH;
  logic [9:0]  cfg_data_i     = '0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata   = '0;  // [7:0] pixel
  logic        s_axis_tuser   = CMD_LOAD;  // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [15:0] m_axis_tdata;         // [9:0] coefficient, [15:10] zero
  logic        m_axis_tlast;
  logic        m_axis_tuser;         // [0] status

  haar_lifting_dwt_2d_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow of the block: frame store, row pass store, counts and size registers
  coef_t        frame_mem [MEM_DEPTH];
  coef_t        row_mem   [MEM_DEPTH];
  logic [9:0]   width_reg  = 10'd512;
  logic [9:0]   height_reg = 10'd512;
  int unsigned  loaded_cnt = 0;
  int unsigned  read_cnt   = 0;
  bit           frame_done = 1'b0;
  coef_result_t coef_q[$];
  int unsigned  mismatch_cnt = 0;
  int unsigned  random_items = 0;
  bit           steady = 1'b0;  // no gaps on either side while set
  int unsigned  stall_left = 0;

  // Round down to even, then clamp to 2..MAX_DIM
  function automatic int unsigned eff_dim(logic [9:0] v);
    int unsigned r;
    r = {v[9:1], 1'b0};
    if (r < 2) r = 2;
    if (r > MAX_DIM) r = MAX_DIM;
    return r;
  endfunction

  function automatic int unsigned frame_pixels();
    return eff_dim(width_reg) * eff_dim(height_reg);
  endfunction

  function automatic void restart_frame();
    loaded_cnt = 0;
    read_cnt   = 0;
    frame_done = 1'b0;
  endfunction

  // Row pass into row_mem, then column pass back into frame_mem
  function automatic void run_lifting(int unsigned w, int unsigned h);
    int unsigned i, j, hw, hh;
    int e, o, d;
    hw = w / 2;
    hh = h / 2;
    for (i = 0; i < h; i++)
      for (j = 0; j < hw; j++) begin
        e = frame_mem[i*w + 2*j];
        o = frame_mem[i*w + 2*j + 1];
        d = o - e;
        row_mem[i*w + hw + j] = coef_t'(d);
        row_mem[i*w + j]      = coef_t'(e + (d >>> 1));
      end
    for (j = 0; j < w; j++)
      for (i = 0; i < hh; i++) begin
        e = row_mem[(2*i)*w + j];
        o = row_mem[(2*i + 1)*w + j];
        d = o - e;
        frame_mem[(hh + i)*w + j] = coef_t'(d);
        frame_mem[i*w + j]        = coef_t'(e + (d >>> 1));
      end
  endfunction

  // Advance the shadow by one accepted transfer; queue a result for a read
  function automatic void predict_item(logic cmd, logic [7:0] pixel);
    int unsigned total;
    coef_result_t r;
    total = frame_pixels();
    if (cmd == CMD_LOAD) begin
      if (!frame_done && loaded_cnt < total) begin
        frame_mem[loaded_cnt] = coef_t'({2'b00, pixel});
        loaded_cnt++;
        if (loaded_cnt == total) begin
          run_lifting(eff_dim(width_reg), eff_dim(height_reg));
          frame_done = 1'b1;
        end
      end
    end else if (!frame_done || read_cnt >= total) begin
      r.coefficient = '0;
      r.last        = 1'b0;
      r.status      = ST_NOT_READY;
      coef_q.push_back(r);
    end else begin
      r.coefficient = frame_mem[read_cnt];
      r.status      = ST_OK;
      read_cnt++;
      r.last = (read_cnt == total);
      if (r.last) restart_frame();
      coef_q.push_back(r);
    end
  endfunction

  // Track register writes and input transfers, check each output transfer
  always @(posedge clk_i) begin : check_results
    coef_result_t got, want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_WIDTH) width_reg = cfg_data_i;
        else height_reg = cfg_data_i;
        restart_frame();
      end
      if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got.coefficient = m_axis_tdata[COEF_W-1:0];
        got.last        = m_axis_tlast;
        got.status      = m_axis_tuser;
        if (coef_q.size() == 0) begin
          $error("unexpected result: coefficient %0d last %0b status %0b",
                 got.coefficient, got.last, got.status);
          mismatch_cnt++;
        end else begin
          want = coef_q.pop_front();
          if (got.coefficient !== want.coefficient) begin
            $error("coefficient: expected %0d, got %0d", want.coefficient, got.coefficient);
            mismatch_cnt++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            mismatch_cnt++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, got.status);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Stall the result side at random
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else begin
      m_axis_tready = 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Present one item, hold it until the transfer; leaves tvalid high
  task automatic send_item(input logic cmd, input logic [7:0] pixel);
    int unsigned gap;
    gap = (!steady && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = 8'($urandom);
      s_axis_tuser  = 1'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = pixel;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic load_pixels(input int unsigned n);
    repeat (n) send_item(CMD_LOAD, 8'($urandom));
  endtask

  task automatic read_coefs(input int unsigned n);
    repeat (n) send_item(CMD_READ, 8'($urandom));
  endtask

  // Hold the sender until every result is out and any lifting pass is over
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (coef_q.size() != 0) @(negedge clk_i);
    repeat (frame_done ? 2 * (frame_pixels() + 3) + 8 : 4) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [9:0] value);
    wait_drained();
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic set_size(input logic [9:0] w, input logic [9:0] h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // Reads and two loads at the reset size before any frame is complete
  task automatic test_reset_state();
    read_coefs(1);
    send_item(CMD_LOAD, 8'h00);
    send_item(CMD_LOAD, 8'hFF);
    read_coefs(1);
  endtask

  // Smallest frame with extreme pixels, a load while ready and a read past the end
  task automatic test_tiny_frame();
    set_size(10'd2, 10'd2);
    send_item(CMD_LOAD, 8'h00);
    send_item(CMD_LOAD, 8'hFF);
    send_item(CMD_LOAD, 8'hFF);
    send_item(CMD_LOAD, 8'h00);
    send_item(CMD_LOAD, 8'h5A);
    read_coefs(5);
    send_item(CMD_LOAD, 8'hFF);
    send_item(CMD_LOAD, 8'h00);
    send_item(CMD_LOAD, 8'h00);
    send_item(CMD_LOAD, 8'hFF);
    read_coefs(4);
  endtask

  // Odd and below-range register values
  task automatic test_size_rounding();
    set_size(10'd3, 10'd1);
    load_pixels(4);
    read_coefs(4);
    set_size(10'd0, 10'd5);
    load_pixels(8);
    read_coefs(8);
  endtask

  // Register writes in the middle of loading and of reading
  task automatic test_restart();
    set_size(10'd4, 10'd4);
    load_pixels(7);
    write_reg(REG_HEIGHT, 10'd4);
    load_pixels(16);
    read_coefs(5);
    write_reg(REG_WIDTH, 10'd4);
    read_coefs(1);
    load_pixels(16);
    read_coefs(16);
  endtask

  // Widest and tallest sizes, partly loaded so reads find the frame not ready;
  // the tall one with no gaps
  task automatic test_extreme_sizes();
    set_size(10'd1023, 10'd0);
    load_pixels(40);
    read_coefs(2);
    set_size(10'd1, 10'd513);
    steady = 1'b1;
    load_pixels(40);
    read_coefs(2);
    steady = 1'b0;
  endtask

  function automatic logic [9:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 10'($urandom_range(0, 1));
    if (r == 1) return 10'({$urandom_range(1, 5), 1'b1});
    return 10'({$urandom_range(1, 5), 1'b0});
  endfunction

  // Mostly whole frames with random pixels, some stray and broken sequences
  task automatic test_random_frames();
    int unsigned total, n, k;
    logic [9:0] w, h;
    while (random_items < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      w = pick_dim();
      h = pick_dim();
      if ($urandom_range(0, 1)) set_size(w, h);
      else begin
        write_reg(REG_HEIGHT, h);
        write_reg(REG_WIDTH, w);
      end
      total = frame_pixels();
      if ($urandom_range(0, 9) == 0) begin
        // noise: commands in any order
        n = $urandom_range(5, 30);
        repeat (n) send_item(1'($urandom), 8'($urandom));
        random_items += n;
      end else begin
        for (k = 0; k < total; k++) begin
          if ($urandom_range(0, 19) == 0) begin
            read_coefs(1);
            random_items++;
          end
          load_pixels(1);
          random_items++;
        end
        if ($urandom_range(0, 7) == 0) wait_drained();
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total) : total;
        for (k = 0; k < n; k++) begin
          if ($urandom_range(0, 19) == 0) load_pixels(1);
          read_coefs(1);
          random_items++;
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_tiny_frame();
    test_size_rounding();
    test_restart();
    test_extreme_sizes();
    test_random_frames();
    wait_drained();
    repeat (8) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
